FILE: src/tpq_pkg.sv
package tpq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int AW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 64;
    localparam int PKT_W       = 16;
    localparam int NODE_W      = 8;
    localparam int CNT_W       = 6;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        logic [PKT_W-1:0]  packet_ref;
        logic [NODE_W-1:0] node_id;
    } t_entry;

    // Result of the shared step unit for the current sequencer step.
    typedef struct packed {
        logic          due;
        logic [AW-1:0] rd_addr;
        logic [AW-1:0] wr_addr;
    } t_step_res;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_INS_CMP   = 6'b000010,
        S_INS_FRONT = 6'b000100,
        S_REL_RD    = 6'b001000,
        S_REL_CHK   = 6'b010000,
        S_RESP      = 6'b100000
    } t_state;

endpackage

FILE: src/tpq_if.sv
interface tpq_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [tpq_pkg::TIME_W-1:0] event_time;
    logic [tpq_pkg::PKT_W-1:0]  packet_ref;
    logic [tpq_pkg::NODE_W-1:0] node_id;

    modport source (output valid, kind, event_time, packet_ref, node_id, input ready);
    modport sink   (input valid, kind, event_time, packet_ref, node_id, output ready);
endinterface

interface tpq_out_if;
    logic                       valid;
    logic                       ready;
    logic                       sent;
    logic [tpq_pkg::PKT_W-1:0]  out_packet_ref;
    logic [tpq_pkg::NODE_W-1:0] out_node_id;
    logic [tpq_pkg::CNT_W-1:0]  released_count;
    logic [tpq_pkg::TIME_W-1:0] next_time;
    logic                       dropped;
    logic                       last;

    modport source (output valid, sent, out_packet_ref, out_node_id, released_count,
                    next_time, dropped, last, input ready);
    modport sink   (input valid, sent, out_packet_ref, out_node_id, released_count,
                    next_time, dropped, last, output ready);
endinterface

FILE: src/tpq_ram.sv
module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/tpq_step_unit.sv
module tpq_step_unit (
    input  logic [tpq_pkg::AW-1:0]     i_head,
    input  logic [tpq_pkg::AW-1:0]     i_rd_lidx,
    input  logic [tpq_pkg::AW-1:0]     i_wr_lidx,
    input  logic [tpq_pkg::TIME_W-1:0] i_entry_time,
    input  logic [tpq_pkg::TIME_W-1:0] i_key_time,
    output tpq_pkg::t_step_res         o_res
);

    localparam int AW = tpq_pkg::AW;

    logic [AW:0] rd_sum;
    logic [AW:0] wr_sum;
    logic [AW:0] depth_w;

    // Logical slots sit behind the head in a ring; the sum stays below
    // twice the depth, so one compare and subtract wraps it.
    assign depth_w = (AW+1)'(tpq_pkg::QUEUE_DEPTH);
    assign rd_sum  = {1'b0, i_head} + {1'b0, i_rd_lidx};
    assign wr_sum  = {1'b0, i_head} + {1'b0, i_wr_lidx};

    always_comb begin
        o_res.due     = (i_entry_time <= i_key_time);
        o_res.rd_addr = (rd_sum >= depth_w) ? AW'(rd_sum - depth_w) : AW'(rd_sum);
        o_res.wr_addr = (wr_sum >= depth_w) ? AW'(wr_sum - depth_w) : AW'(wr_sum);
    end

endmodule

FILE: src/timed_packet_release_queue.sv
// Channel   Dir  Handshake          Payload
// i_in      in   valid/ready        kind, event_time, packet_ref, node_id
// o_out     out  valid/ready        sent, out_packet_ref, out_node_id,
//                                   released_count, next_time, dropped, last
//
// A schedule walks back from the tail over each held entry later than the new one,
// which moves up one ring slot; a dropped schedule goes straight to the status transfer.
// A release pops each due packet and then sends the status transfer; each release
// step is one registered memory read and one compare.
// Reset empties the queue at once and never clears the entry memory. A stalled
// output holds the sequencer, and no item is taken until the last result is loaded.
module timed_packet_release_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tpq_in_if.sink           i_in,
    tpq_out_if.source        o_out
);

    localparam int AW = tpq_pkg::AW;
    localparam int CW = tpq_pkg::CW;

    tpq_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;      // entries held
    logic [AW-1:0]      r_head, n_head;    // ring slot of the earliest entry
    logic [AW-1:0]      r_idx, n_idx;      // logical slot under inspection
    logic [tpq_pkg::CNT_W-1:0]  r_rcnt, n_rcnt;
    logic [tpq_pkg::TIME_W-1:0] r_next, n_next;
    logic               r_drop, n_drop;
    logic               r_kind;
    logic [tpq_pkg::TIME_W-1:0] r_key;
    logic [tpq_pkg::PKT_W-1:0]  r_pkt;
    logic [tpq_pkg::NODE_W-1:0] r_node;

    // Output register so the next step can proceed while a result waits.
    logic               r_ovalid, n_ovalid;
    logic               r_sent, n_sent;
    logic [tpq_pkg::PKT_W-1:0]  r_opkt, n_opkt;
    logic [tpq_pkg::NODE_W-1:0] r_onode, n_onode;
    logic [tpq_pkg::CNT_W-1:0]  r_ocnt, n_ocnt;
    logic [tpq_pkg::TIME_W-1:0] r_onext, n_onext;
    logic               r_odrop, n_odrop;
    logic               r_olast, n_olast;

    logic               accept;
    logic               out_free;
    logic [AW-1:0]      rd_lidx;
    logic [AW-1:0]      wr_lidx;
    logic               rd_en;
    logic               wr_en;
    tpq_pkg::t_entry    wr_data;
    tpq_pkg::t_entry    rd_entry;
    tpq_pkg::t_entry    new_entry;
    tpq_pkg::t_step_res step;

    assign i_in.ready = (r_state == tpq_pkg::S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_ovalid || o_out.ready;

    assign new_entry.event_time = r_key;
    assign new_entry.packet_ref = r_pkt;
    assign new_entry.node_id    = r_node;

    tpq_step_unit u_step (
        .i_head       (r_head),
        .i_rd_lidx    (rd_lidx),
        .i_wr_lidx    (wr_lidx),
        .i_entry_time (rd_entry.event_time),
        .i_key_time   (r_key),
        .o_res        (step)
    );

    tpq_ram #(
        .WIDTH ($bits(tpq_pkg::t_entry)),
        .DEPTH (tpq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (step.wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (step.rd_addr),
        .o_rd_data (rd_entry)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_idx    = r_idx;
        n_rcnt   = r_rcnt;
        n_next   = r_next;
        n_drop   = r_drop;
        rd_lidx  = '0;
        wr_lidx  = '0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_data  = new_entry;
        n_ovalid = r_ovalid && !o_out.ready;
        n_sent   = r_sent;
        n_opkt   = r_opkt;
        n_onode  = r_onode;
        n_ocnt   = r_ocnt;
        n_onext  = r_onext;
        n_odrop  = r_odrop;
        n_olast  = r_olast;

        unique case (r_state)
            tpq_pkg::S_IDLE: begin
                n_rcnt = '0;
                n_next = '0;
                n_drop = 1'b0;
                if (accept) begin
                    if (i_in.kind) begin
                        n_state = tpq_pkg::S_REL_RD;
                    end else if (r_cnt == CW'(tpq_pkg::QUEUE_DEPTH)) begin
                        n_drop  = 1'b1;
                        n_state = tpq_pkg::S_RESP;
                    end else if (r_cnt == '0) begin
                        n_state = tpq_pkg::S_INS_FRONT;
                    end else begin
                        // Walk backward from the tail, shifting later entries up.
                        n_idx   = AW'(r_cnt - CW'(1));
                        rd_lidx = AW'(r_cnt - CW'(1));
                        rd_en   = 1'b1;
                        n_state = tpq_pkg::S_INS_CMP;
                    end
                end
            end

            tpq_pkg::S_INS_CMP: begin
                wr_lidx = r_idx + AW'(1);
                wr_en   = 1'b1;
                if (step.due) begin
                    // Held entry is not later: the new one goes right behind it.
                    wr_data = new_entry;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = tpq_pkg::S_RESP;
                end else begin
                    wr_data = rd_entry;
                    if (r_idx == '0) begin
                        n_state = tpq_pkg::S_INS_FRONT;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        rd_lidx = r_idx - AW'(1);
                        rd_en   = 1'b1;
                    end
                end
            end

            tpq_pkg::S_INS_FRONT: begin
                wr_lidx = '0;
                wr_en   = 1'b1;
                wr_data = new_entry;
                n_cnt   = r_cnt + CW'(1);
                n_state = tpq_pkg::S_RESP;
            end

            tpq_pkg::S_REL_RD: begin
                if (r_cnt == '0) begin
                    n_next  = '0;
                    n_state = tpq_pkg::S_RESP;
                end else begin
                    rd_lidx = '0;
                    rd_en   = 1'b1;
                    n_state = tpq_pkg::S_REL_CHK;
                end
            end

            tpq_pkg::S_REL_CHK: begin
                if (!step.due) begin
                    n_next  = rd_entry.event_time;
                    n_state = tpq_pkg::S_RESP;
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_sent   = 1'b1;
                    n_opkt   = rd_entry.packet_ref;
                    n_onode  = rd_entry.node_id;
                    n_ocnt   = '0;
                    n_onext  = '0;
                    n_odrop  = 1'b0;
                    n_olast  = 1'b0;
                    n_rcnt   = r_rcnt + tpq_pkg::CNT_W'(1);
                    n_cnt    = r_cnt - CW'(1);
                    n_head   = (r_head == AW'(tpq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : r_head + AW'(1);
                    n_state  = tpq_pkg::S_REL_RD;
                end
            end

            tpq_pkg::S_RESP: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_sent   = 1'b0;
                    n_opkt   = '0;
                    n_onode  = '0;
                    n_ocnt   = r_kind ? r_rcnt : '0;
                    n_onext  = r_kind ? r_next : '0;
                    n_odrop  = r_drop;
                    n_olast  = 1'b1;
                    n_state  = tpq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tpq_pkg::S_IDLE;
            r_cnt    <= '0;
            r_head   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_head   <= n_head;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_rcnt  <= n_rcnt;
        r_next  <= n_next;
        r_drop  <= n_drop;
        r_sent  <= n_sent;
        r_opkt  <= n_opkt;
        r_onode <= n_onode;
        r_ocnt  <= n_ocnt;
        r_onext <= n_onext;
        r_odrop <= n_odrop;
        r_olast <= n_olast;
        if (accept) begin
            r_kind <= i_in.kind;
            r_key  <= i_in.event_time;
            r_pkt  <= i_in.packet_ref;
            r_node <= i_in.node_id;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.sent           = r_sent;
    assign o_out.out_packet_ref = r_opkt;
    assign o_out.out_node_id    = r_onode;
    assign o_out.released_count = r_ocnt;
    assign o_out.next_time      = r_onext;
    assign o_out.dropped        = r_odrop;
    assign o_out.last           = r_olast;

`ifndef SYNTH
    // The occupancy never passes the ring size.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(tpq_pkg::QUEUE_DEPTH))
        else $error("queue occupancy exceeds depth");

    // An insertion walk never starts on a full queue.
    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpq_pkg::S_INS_CMP) |-> (r_cnt != CW'(tpq_pkg::QUEUE_DEPTH)))
        else $error("insertion on a full queue");

    // An accepted item always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != tpq_pkg::S_IDLE))
        else $error("accepted item did not start the sequencer");

    // A popped packet shrinks the queue by exactly one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpq_pkg::S_REL_CHK && step.due && out_free)
            |=> (r_cnt == $past(r_cnt) - CW'(1)))
        else $error("release did not remove one entry");
`endif

endmodule
